[rtl/ipalm_pkg.sv]
// ipalm_pkg: shared types and constants for the IPv4 allow-list parse and match unit.
// Used by ipalm_parser, ipalm_matcher and the top level; no dependencies.
`default_nettype none

package ipalm_pkg;

    // default table depth
    localparam int MAX_ENTRIES_DEF = 32;

    // stream payload widths
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    // list characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;

    localparam logic [7:0] PREFIX_FULL = 8'd32;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_STAR     = 3'd2,
        ST_BAD_ADDR = 3'd3,
        ST_BAD_PREF = 3'd4,
        ST_TOO_MANY = 3'd5
    } status_t;

    // character parser phase
    typedef enum logic [2:0] {
        PH_LIST_START,
        PH_IP_EMPTY,
        PH_IP_BODY,
        PH_MASK_EMPTY,
        PH_MASK_BODY,
        PH_STAR,
        PH_SKIP
    } phase_t;

    // top-level sequencer
    typedef enum logic [2:0] {
        T_IDLE,
        T_CHAR,
        T_QRY,
        T_WAIT,
        T_POST
    } top_state_t;

    // match scan sequencer
    typedef enum logic [0:0] {
        M_IDLE,
        M_SCAN
    } match_state_t;

    // table write from parser to matcher
    typedef struct packed {
        logic        we;
        logic [31:0] subnet;
        logic [5:0]  prefix;
    } entry_wr_t;

    // terminator result from parser
    typedef struct packed {
        logic    done;
        status_t status;
    } parse_rsp_t;

    // query result from matcher
    typedef struct packed {
        logic done;
        logic allowed;
    } match_rsp_t;

endpackage

`default_nettype wire

[rtl/ipalm_parser.sv]
// ipalm_parser: allow-list character parser; builds entries and tracks the entry count.
// Depends on ipalm_pkg; table writes go to ipalm_matcher.
`default_nettype none

module ipalm_parser #(
    parameter int MAX_ENTRIES = ipalm_pkg::MAX_ENTRIES_DEF
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           step_i,
    input  wire  [7:0]                    char_i,
    output ipalm_pkg::parse_rsp_t         rsp_o,
    output ipalm_pkg::entry_wr_t          wr_o,
    output logic [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_addr_o,
    output logic [$clog2(MAX_ENTRIES + 1)-1:0] total_o
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    ipalm_pkg::phase_t  phase_reg, phase_next;
    ipalm_pkg::status_t pend_reg, pend_next;
    logic [0:3][7:0]    oct_reg, oct_next;
    logic [1:0]         idx_reg, idx_next;
    logic [7:0]         pre_reg, pre_next;
    logic [CW-1:0]      total_reg, total_next;

    // effective state after the new-list step
    ipalm_pkg::phase_t  eff_phase;
    logic [0:3][7:0]    eff_oct;
    logic [1:0]         eff_idx;
    logic [7:0]         eff_pre;
    logic [CW-1:0]      eff_total;

    // entry close check
    logic               fin_err;
    ipalm_pkg::status_t fin_code;
    logic [5:0]         fin_pre;

    // error raised in this step
    logic               err_hit;
    ipalm_pkg::status_t err_code;

    logic               is_digit;
    logic [7:0]         digit;

    assign is_digit = char_i inside {[ipalm_pkg::CH_0:ipalm_pkg::CH_9]};
    assign digit    = char_i - ipalm_pkg::CH_0;

    // new-list handling ahead of the character itself
    always_comb begin
        eff_phase = phase_reg;
        eff_oct   = oct_reg;
        eff_idx   = idx_reg;
        eff_pre   = pre_reg;
        eff_total = total_reg;
        if (phase_reg == ipalm_pkg::PH_LIST_START && char_i != ipalm_pkg::CH_NUL) begin
            eff_total = '0;
            if (char_i == ipalm_pkg::CH_STAR) begin
                eff_phase = ipalm_pkg::PH_STAR;
            end else begin
                eff_phase = ipalm_pkg::PH_IP_EMPTY;
                eff_oct   = '0;
                eff_idx   = '0;
                eff_pre   = '0;
            end
        end
    end

    // closing the entry in progress: prefix check and overflow check
    always_comb begin
        fin_err  = 1'b0;
        fin_code = ipalm_pkg::ST_OK;
        fin_pre  = 6'(eff_pre);
        if (eff_phase == ipalm_pkg::PH_IP_EMPTY) begin
            fin_err  = 1'b1;
            fin_code = ipalm_pkg::ST_BAD_ADDR;
        end else if (eff_phase == ipalm_pkg::PH_IP_BODY) begin
            fin_pre = 6'(ipalm_pkg::PREFIX_FULL);
        end else if (eff_phase == ipalm_pkg::PH_MASK_EMPTY || eff_pre == 8'd0 ||
                     eff_pre > ipalm_pkg::PREFIX_FULL) begin
            fin_err  = 1'b1;
            fin_code = ipalm_pkg::ST_BAD_PREF;
        end
        if (!fin_err && eff_total >= CW'(MAX_ENTRIES)) begin
            fin_err  = 1'b1;
            fin_code = ipalm_pkg::ST_TOO_MANY;
        end
    end

    // next state for one character
    always_comb begin
        phase_next = phase_reg;
        pend_next  = pend_reg;
        oct_next   = oct_reg;
        idx_next   = idx_reg;
        pre_next   = pre_reg;
        total_next = total_reg;
        err_hit    = 1'b0;
        err_code   = ipalm_pkg::ST_OK;
        wr_o.we     = 1'b0;
        wr_o.subnet = eff_oct;
        wr_o.prefix = fin_pre;
        rsp_o.done   = 1'b0;
        rsp_o.status = ipalm_pkg::ST_OK;

        if (step_i && char_i == ipalm_pkg::CH_NUL) begin
            // terminator: report and start a fresh list
            rsp_o.done = 1'b1;
            case (phase_reg)
                ipalm_pkg::PH_LIST_START: begin
                    total_next   = '0;
                    rsp_o.status = ipalm_pkg::ST_EMPTY;
                end
                ipalm_pkg::PH_STAR: begin
                    total_next = '0;
                end
                ipalm_pkg::PH_SKIP: begin
                    rsp_o.status = pend_reg;
                end
                default: begin
                    if (fin_err) begin
                        rsp_o.status = fin_code;
                        if (fin_code != ipalm_pkg::ST_TOO_MANY) begin
                            total_next = '0;
                        end
                    end else begin
                        wr_o.we    = 1'b1;
                        total_next = total_reg + CW'(1);
                    end
                end
            endcase
            oct_next   = '0;
            idx_next   = '0;
            pre_next   = '0;
            pend_next  = ipalm_pkg::ST_OK;
            phase_next = ipalm_pkg::PH_LIST_START;
        end else if (step_i) begin
            phase_next = eff_phase;
            oct_next   = eff_oct;
            idx_next   = eff_idx;
            pre_next   = eff_pre;
            total_next = eff_total;
            if (phase_reg == ipalm_pkg::PH_LIST_START) begin
                pend_next = ipalm_pkg::ST_OK;
            end
            // star on a new list only changes phase and clears the count
            if (!(phase_reg == ipalm_pkg::PH_LIST_START && char_i == ipalm_pkg::CH_STAR)) begin
                case (eff_phase)
                    ipalm_pkg::PH_IP_EMPTY,
                    ipalm_pkg::PH_IP_BODY: begin
                        if (is_digit) begin
                            oct_next[eff_idx] = (eff_oct[eff_idx] << 3) +
                                                (eff_oct[eff_idx] << 1) + digit;
                            phase_next = ipalm_pkg::PH_IP_BODY;
                        end else if (char_i == ipalm_pkg::CH_DOT) begin
                            if (eff_idx == 2'd3) begin
                                err_hit  = 1'b1;
                                err_code = ipalm_pkg::ST_BAD_ADDR;
                            end else begin
                                idx_next   = eff_idx + 2'd1;
                                phase_next = ipalm_pkg::PH_IP_BODY;
                            end
                        end else if (char_i == ipalm_pkg::CH_PLUS) begin
                            if (fin_err) begin
                                err_hit  = 1'b1;
                                err_code = fin_code;
                            end else begin
                                wr_o.we    = 1'b1;
                                total_next = eff_total + CW'(1);
                                oct_next   = '0;
                                idx_next   = '0;
                                pre_next   = '0;
                                phase_next = ipalm_pkg::PH_IP_EMPTY;
                            end
                        end else if (char_i == ipalm_pkg::CH_SLASH) begin
                            if (eff_phase == ipalm_pkg::PH_IP_EMPTY) begin
                                err_hit  = 1'b1;
                                err_code = ipalm_pkg::ST_BAD_ADDR;
                            end else begin
                                pre_next   = '0;
                                phase_next = ipalm_pkg::PH_MASK_EMPTY;
                            end
                        end else begin
                            err_hit  = 1'b1;
                            err_code = ipalm_pkg::ST_BAD_ADDR;
                        end
                    end
                    ipalm_pkg::PH_MASK_EMPTY,
                    ipalm_pkg::PH_MASK_BODY: begin
                        if (is_digit) begin
                            pre_next   = (eff_pre << 3) + (eff_pre << 1) + digit;
                            phase_next = ipalm_pkg::PH_MASK_BODY;
                        end else if (char_i == ipalm_pkg::CH_PLUS) begin
                            if (fin_err) begin
                                err_hit  = 1'b1;
                                err_code = fin_code;
                            end else begin
                                wr_o.we    = 1'b1;
                                total_next = eff_total + CW'(1);
                                oct_next   = '0;
                                idx_next   = '0;
                                pre_next   = '0;
                                phase_next = ipalm_pkg::PH_IP_EMPTY;
                            end
                        end else begin
                            err_hit  = 1'b1;
                            err_code = ipalm_pkg::ST_BAD_PREF;
                        end
                    end
                    ipalm_pkg::PH_STAR: begin
                        err_hit  = 1'b1;
                        err_code = ipalm_pkg::ST_STAR;
                    end
                    default: begin
                    end
                endcase
            end
            // error: hold the code until the terminator, drop the list on parse errors
            if (err_hit) begin
                pend_next  = err_code;
                phase_next = ipalm_pkg::PH_SKIP;
                if (err_code == ipalm_pkg::ST_BAD_ADDR || err_code == ipalm_pkg::ST_BAD_PREF) begin
                    total_next = '0;
                end
            end
        end
    end

    assign wr_addr_o = eff_total[AW-1:0];
    assign total_o   = total_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ipalm_pkg::PH_LIST_START;
            pend_reg  <= ipalm_pkg::ST_OK;
            oct_reg   <= '0;
            idx_reg   <= '0;
            pre_reg   <= '0;
            total_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pend_reg  <= pend_next;
            oct_reg   <= oct_next;
            idx_reg   <= idx_next;
            pre_reg   <= pre_next;
            total_reg <= total_next;
        end
    end

`ifndef SYNTHESIS
    // count never passes the table depth
    a_total_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= CW'(MAX_ENTRIES))
        else $error("entry count above table depth");

    // a stored entry grows the count by exactly one
    a_store_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_o.we |=> total_reg == $past(eff_total) + CW'(1))
        else $error("entry store did not advance the count");

    // writes land inside the table
    a_store_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_o.we |-> eff_total < CW'(MAX_ENTRIES))
        else $error("entry store past table end");
`endif

endmodule

`default_nettype wire

[rtl/ipalm_matcher.sv]
// ipalm_matcher: subnet/prefix table and the sequential masked-compare scan for queries.
// Depends on ipalm_pkg; table writes come from ipalm_parser.
`default_nettype none

module ipalm_matcher #(
    parameter int MAX_ENTRIES = ipalm_pkg::MAX_ENTRIES_DEF
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       start_i,
    input  wire  [31:0]               peer_i,
    input  wire  [$clog2(MAX_ENTRIES + 1)-1:0] total_i,
    input  ipalm_pkg::entry_wr_t      wr_i,
    input  wire  [((MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1)-1:0] wr_addr_i,
    output ipalm_pkg::match_rsp_t     rsp_o
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    // entry table, written by the parser, read once per scan step
    logic [31:0] subnet_mem [MAX_ENTRIES];
    logic [5:0]  prefix_mem [MAX_ENTRIES];
    logic [31:0] subnet_q;
    logic [5:0]  prefix_q;

    ipalm_pkg::match_state_t state_reg, state_next;
    logic [CW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] total_reg, total_next;
    logic [31:0]   peer_reg, peer_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic          hit_reg, hit_next;
    logic [31:0]   mask;
    logic          match;

    // table write and registered read
    always_ff @(posedge aclk) begin
        if (wr_i.we) begin
            subnet_mem[wr_addr_i] <= wr_i.subnet;
            prefix_mem[wr_addr_i] <= wr_i.prefix;
        end
        subnet_q <= subnet_mem[rd_idx_reg[AW-1:0]];
        prefix_q <= prefix_mem[rd_idx_reg[AW-1:0]];
    end

    // prefix to mask: top bits set, count given by the prefix (32 and up = all)
    always_comb begin
        for (int j = 0; j < 32; j++) begin
            mask[31-j] = 6'(j) < prefix_q;
        end
    end

    assign match = (peer_reg & mask) == subnet_q;

    // scan sequencer: one read issued and one compare done per cycle
    always_comb begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        total_next   = total_reg;
        peer_next    = peer_reg;
        cmp_vld_next = 1'b0;
        hit_next     = hit_reg;
        rsp_o.done    = 1'b0;
        rsp_o.allowed = hit_reg || (total_reg == '0);
        case (state_reg)
            ipalm_pkg::M_IDLE: begin
                if (start_i) begin
                    total_next  = total_i;
                    peer_next   = peer_i;
                    rd_idx_next = '0;
                    hit_next    = 1'b0;
                    state_next  = ipalm_pkg::M_SCAN;
                end
            end
            ipalm_pkg::M_SCAN: begin
                if (rd_idx_reg != total_reg) begin
                    rd_idx_next  = rd_idx_reg + CW'(1);
                    cmp_vld_next = 1'b1;
                end
                if (cmp_vld_reg && match) begin
                    hit_next = 1'b1;
                end
                if (rd_idx_reg == total_reg && !cmp_vld_reg) begin
                    rsp_o.done = 1'b1;
                    state_next = ipalm_pkg::M_IDLE;
                end
            end
            default: begin
                state_next = ipalm_pkg::M_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ipalm_pkg::M_IDLE;
            cmp_vld_reg <= 1'b0;
            hit_reg     <= 1'b0;
            rd_idx_reg  <= '0;
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            hit_reg     <= hit_next;
            rd_idx_reg  <= rd_idx_next;
            total_reg   <= total_next;
        end
        peer_reg <= peer_next;
    end

`ifndef SYNTHESIS
    // read pointer stays within the captured entry count
    a_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ipalm_pkg::M_SCAN |-> rd_idx_reg <= total_reg)
        else $error("scan pointer past entry count");

    // compares only follow an issued read
    a_cmp_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_vld_reg |-> $past(state_reg) == ipalm_pkg::M_SCAN)
        else $error("compare without a scan read");
`endif

endmodule

`default_nettype wire

[rtl/ipv4_allow_list_parse_and_match_unit.sv]
// IPv4 allow-list parse and match unit: list characters fill a subnet/prefix table,
// peer queries are checked against it one entry per cycle.
// Input is accepted only in T_IDLE. A list character steps the parser in T_CHAR, and a terminator
// then posts its result in T_POST. A query starts the scan in T_QRY and waits in T_WAIT while the
// single masked compare walks the stored entries, then posts in T_POST once the output is free.
// Reset (aresetn low, synchronous) starts a new list with no entries; the table is not cleared.
`default_nettype none

module ipv4_allow_list_parse_and_match_unit #(
    parameter int MAX_ENTRIES = ipalm_pkg::MAX_ENTRIES_DEF
) (
    input  wire                            aclk,
    input  wire                            aresetn,
    // input stream
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [ipalm_pkg::S_DATA_W-1:0] s_axis_tdata,  // [7:0] text_char, [39:8] peer_address
    input  wire                            s_axis_tuser,  // [0] action
    // result stream
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [ipalm_pkg::M_DATA_W-1:0] m_axis_tdata   // [2:0] status, [3] allowed,
                                                          // [9:4] entry_count, [15:10] zero
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    ipalm_pkg::top_state_t state_reg, state_next;

    logic [7:0]    char_reg, char_next;
    logic [31:0]   peer_reg, peer_next;
    logic [2:0]    res_status_reg, res_status_next;
    logic          res_allowed_reg, res_allowed_next;
    logic          m_valid_reg, m_valid_next;
    logic [ipalm_pkg::M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                  step;
    logic                  start;
    ipalm_pkg::parse_rsp_t parse_rsp;
    ipalm_pkg::match_rsp_t match_rsp;
    ipalm_pkg::entry_wr_t  entry_wr;
    logic [AW-1:0]         entry_wr_addr;
    logic [CW-1:0]         entry_total;

    ipalm_parser #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_i    (step),
        .char_i    (char_reg),
        .rsp_o     (parse_rsp),
        .wr_o      (entry_wr),
        .wr_addr_o (entry_wr_addr),
        .total_o   (entry_total)
    );

    ipalm_matcher #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_matcher (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start_i   (start),
        .peer_i    (peer_reg),
        .total_i   (entry_total),
        .wr_i      (entry_wr),
        .wr_addr_i (entry_wr_addr),
        .rsp_o     (match_rsp)
    );

    assign s_axis_tready = (state_reg == ipalm_pkg::T_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // item sequencer and output register
    always_comb begin
        state_next       = state_reg;
        char_next        = char_reg;
        peer_next        = peer_reg;
        res_status_next  = res_status_reg;
        res_allowed_next = res_allowed_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_axis_tready;
        step             = 1'b0;
        start            = 1'b0;
        case (state_reg)
            ipalm_pkg::T_IDLE: begin
                if (s_axis_tvalid) begin
                    char_next  = s_axis_tdata[7:0];
                    peer_next  = s_axis_tdata[39:8];
                    state_next = s_axis_tuser ? ipalm_pkg::T_QRY : ipalm_pkg::T_CHAR;
                end
            end
            ipalm_pkg::T_CHAR: begin
                step = 1'b1;
                if (parse_rsp.done) begin
                    res_status_next  = parse_rsp.status;
                    res_allowed_next = 1'b0;
                    state_next       = ipalm_pkg::T_POST;
                end else begin
                    state_next = ipalm_pkg::T_IDLE;
                end
            end
            ipalm_pkg::T_QRY: begin
                start      = 1'b1;
                state_next = ipalm_pkg::T_WAIT;
            end
            ipalm_pkg::T_WAIT: begin
                if (match_rsp.done) begin
                    res_status_next  = ipalm_pkg::ST_OK;
                    res_allowed_next = match_rsp.allowed;
                    state_next       = ipalm_pkg::T_POST;
                end
            end
            ipalm_pkg::T_POST: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {6'd0, 6'(entry_total), res_allowed_reg, res_status_reg};
                    state_next   = ipalm_pkg::T_IDLE;
                end
            end
            default: begin
                state_next = ipalm_pkg::T_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ipalm_pkg::T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        char_reg        <= char_next;
        peer_reg        <= peer_next;
        res_status_reg  <= res_status_next;
        res_allowed_reg <= res_allowed_next;
        m_data_reg      <= m_data_next;
    end

`ifndef SYNTHESIS
    // a permitted result only comes from a query, whose status is always ok
    a_allowed_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[3] |-> m_data_reg[2:0] == ipalm_pkg::ST_OK)
        else $error("allowed flag set on a terminator result");

    // matcher finishes only while the sequencer waits for it
    a_match_done: assert property (@(posedge aclk) disable iff (!aresetn)
        match_rsp.done |-> state_reg == ipalm_pkg::T_WAIT)
        else $error("query result with no query in flight");

    // parser never steps outside a character transfer
    a_parse_step: assert property (@(posedge aclk) disable iff (!aresetn)
        entry_wr.we |-> state_reg == ipalm_pkg::T_CHAR)
        else $error("table write outside character handling");
`endif

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for ipv4_allow_list_parse_and_match_unit.
// Streams allow-list text and peer queries through the input channel, predicts every
// result in-line and checks it field by field. Depends only on ipalm_pkg and the RTL.
`timescale 1ns / 100ps

module tb;
    import ipalm_pkg::*;

    localparam int TBL_DEPTH    = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 950;
    localparam int CYCLE_LIMIT  = 400_000;
    localparam int DRAIN_CYCLES = 64;
    localparam int HOLD_START   = 1000;
    localparam int HOLD_CYCLES  = 600;
    localparam int MAX_REPORTS  = 60;

    typedef enum logic {
        ACT_TEXT  = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;

    // ways of breaking one entry of a list
    typedef enum int {
        FLT_NONE,
        FLT_JUNK,
        FLT_FIFTH,
        FLT_EMPTY_PFX,
        FLT_PFX_RANGE,
        FLT_EMPTY_ADDR,
        FLT_SLASH_FIRST
    } fault_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  ch;
        logic [31:0] peer;
    } list_item_t;

    typedef struct packed {
        status_t    status;
        logic       allowed;
        logic [5:0] count;
    } verdict_t;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    wire                 s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;  // [7:0] text_char, [39:8] peer_address
    logic                s_axis_tuser  = 1'b0; // [0] action
    wire                 m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    wire  [M_DATA_W-1:0] m_axis_tdata;  // [2:0] status, [3] allowed, [9:4] entry_count

    ipv4_allow_list_parse_and_match_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    list_item_t  stim_q[$];
    verdict_t    verdict_q[$];

    // predictor copy of the allow list and parser
    logic [31:0]       acl_subnet [TBL_DEPTH];
    logic [5:0]        acl_prefix [TBL_DEPTH];
    int unsigned       acl_count    = 0;
    logic [3:0][7:0]   acl_oct      = '0;
    logic [1:0]        acl_oct_idx  = '0;
    logic [7:0]        acl_pref_acc = '0;
    phase_t            acl_phase    = PH_LIST_START;
    status_t           acl_err      = ST_OK;

    // run statistics and error tally
    int n_chars = 0, n_terms = 0, n_queries = 0, n_permitted = 0, peak_count = 0;
    int status_hist [8];
    int n_results = 0, n_errors = 0;

    // stimulus generator bookkeeping: clean entries of the list being built
    logic [31:0] gen_subnets[$];
    logic [5:0]  gen_prefixes[$];

    int gap_left = 0, burst_left = 1;
    int cycle_count = 0;
    int hold_clock = 0, hold_left = 0;
    logic [9:0] rcv_cyc = '0;

    //------------------------------------------------------------------
    // Predictor
    //------------------------------------------------------------------
    function automatic void acl_begin_entry();
        acl_oct      = '0;
        acl_oct_idx  = '0;
        acl_pref_acc = '0;
        acl_phase    = PH_IP_EMPTY;
    endfunction

    function automatic void acl_raise(input status_t code);
        acl_err = code;
        if (code == ST_BAD_ADDR || code == ST_BAD_PREF)
            acl_count = 0;
        acl_phase = PH_SKIP;
    endfunction

    function automatic bit acl_store(input logic [7:0] pfx);
        if (acl_count >= TBL_DEPTH) begin
            acl_raise(ST_TOO_MANY);
            return 1'b0;
        end
        acl_subnet[acl_count] = {acl_oct[0], acl_oct[1], acl_oct[2], acl_oct[3]};
        acl_prefix[acl_count] = pfx[5:0];
        acl_count++;
        return 1'b1;
    endfunction

    // closes the entry in progress; 0 when that raised an error
    function automatic bit acl_finish();
        if (acl_phase == PH_IP_EMPTY) begin
            acl_raise(ST_BAD_ADDR);
            return 1'b0;
        end
        if (acl_phase == PH_IP_BODY)
            return acl_store(PREFIX_FULL);
        if (acl_phase == PH_MASK_EMPTY || acl_pref_acc == 8'd0 || acl_pref_acc > PREFIX_FULL) begin
            acl_raise(ST_BAD_PREF);
            return 1'b0;
        end
        return acl_store(acl_pref_acc);
    endfunction

    function automatic bit acl_permits(input logic [31:0] peer);
        logic [31:0] m;
        if (acl_count == 0)
            return 1'b1;
        for (int i = 0; i < acl_count; i++) begin
            if (acl_prefix[i] == 6'd0)
                m = '0;
            else if (acl_prefix[i] >= 6'd32)
                m = '1;
            else
                m = 32'hFFFF_FFFF << (32 - acl_prefix[i]);
            if ((peer & m) == acl_subnet[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void acl_take_char(input logic [7:0] c);
        bit digit;
        digit = (c >= CH_0) && (c <= CH_9);
        // first character of a list wipes the table
        if (acl_phase == PH_LIST_START) begin
            acl_count = 0;
            acl_err   = ST_OK;
            if (c == CH_STAR) begin
                acl_phase = PH_STAR;
                return;
            end
            acl_begin_entry();
        end
        case (acl_phase)
            PH_IP_EMPTY, PH_IP_BODY: begin
                if (digit) begin
                    acl_oct[acl_oct_idx] = acl_oct[acl_oct_idx] * 8'd10 + (c - CH_0);
                    acl_phase = PH_IP_BODY;
                end else if (c == CH_DOT) begin
                    // a fourth dot would open a fifth octet
                    if (acl_oct_idx == 2'd3) begin
                        acl_raise(ST_BAD_ADDR);
                    end else begin
                        acl_oct_idx++;
                        acl_phase = PH_IP_BODY;
                    end
                end else if (c == CH_PLUS) begin
                    if (acl_finish())
                        acl_begin_entry();
                end else if (c == CH_SLASH) begin
                    if (acl_phase == PH_IP_EMPTY) begin
                        acl_raise(ST_BAD_ADDR);
                    end else begin
                        acl_pref_acc = '0;
                        acl_phase    = PH_MASK_EMPTY;
                    end
                end else begin
                    acl_raise(ST_BAD_ADDR);
                end
            end
            PH_MASK_EMPTY, PH_MASK_BODY: begin
                if (digit) begin
                    acl_pref_acc = acl_pref_acc * 8'd10 + (c - CH_0);
                    acl_phase    = PH_MASK_BODY;
                end else if (c == CH_PLUS) begin
                    if (acl_finish())
                        acl_begin_entry();
                end else begin
                    acl_raise(ST_BAD_PREF);
                end
            end
            PH_STAR: acl_raise(ST_STAR);
            default: ;
        endcase
    endfunction

    function automatic status_t acl_take_end();
        status_t st;
        st = ST_OK;
        case (acl_phase)
            PH_LIST_START: begin
                acl_count = 0;
                st        = ST_EMPTY;
            end
            PH_STAR: acl_count = 0;
            PH_SKIP: st = acl_err;
            default: begin
                if (!acl_finish())
                    st = acl_err;
            end
        endcase
        acl_oct      = '0;
        acl_oct_idx  = '0;
        acl_pref_acc = '0;
        acl_err      = ST_OK;
        acl_phase    = PH_LIST_START;
        return st;
    endfunction

    // called once per accepted input transfer
    function automatic void predict_item(input list_item_t it);
        verdict_t v;
        if (it.action == ACT_QUERY) begin
            v.status  = ST_OK;
            v.allowed = acl_permits(it.peer);
            v.count   = acl_count[5:0];
            verdict_q.push_back(v);
            n_queries++;
            n_permitted += v.allowed;
        end else if (it.ch != CH_NUL) begin
            acl_take_char(it.ch);
            n_chars++;
        end else begin
            v.status  = acl_take_end();
            v.allowed = 1'b0;
            v.count   = acl_count[5:0];
            verdict_q.push_back(v);
            n_terms++;
            status_hist[v.status]++;
        end
        if (acl_count > peak_count)
            peak_count = acl_count;
    endfunction

    //------------------------------------------------------------------
    // Stimulus generation
    //------------------------------------------------------------------
    task automatic add_char(input logic [7:0] c);
        list_item_t it;
        it.action = ACT_TEXT;
        it.ch     = c;
        it.peer   = $urandom();
        stim_q.push_back(it);
    endtask

    task automatic add_query(input logic [31:0] p);
        list_item_t it;
        it.action = ACT_QUERY;
        it.ch     = 8'($urandom_range(0, 255));
        it.peer   = p;
        stim_q.push_back(it);
    endtask

    task automatic add_number(input int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
    endtask

    // query aimed at a clean entry of the current list, or anywhere
    task automatic add_probe();
        int          k;
        logic [31:0] m;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            add_query(32'h0000_0000);
        end else if (k == 1) begin
            add_query(32'hFFFF_FFFF);
        end else if (k < 7 && gen_subnets.size() != 0) begin
            k = $urandom_range(0, gen_subnets.size() - 1);
            m = ~(32'hFFFF_FFFF >> gen_prefixes[k]);
            add_query(gen_subnets[k] | ($urandom() & ~m));
        end else begin
            add_query($urandom());
        end
    endtask

    task automatic add_entry(input fault_t flt, input bit short_form);
        int          n_oct;
        int unsigned pfx;
        bit          has_pfx;
        logic [31:0] ip;
        if (flt == FLT_EMPTY_ADDR)
            return;
        if (flt == FLT_SLASH_FIRST)
            add_char(CH_SLASH);
        n_oct = short_form ? 1 : (($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 4);
        if (flt == FLT_FIFTH)
            n_oct = 4;
        ip = $urandom();
        for (int k = n_oct; k < 4; k++)
            ip[8*(3-k) +: 8] = 8'h00;
        has_pfx = $urandom_range(0, 2) != 0;
        pfx     = short_form ? $urandom_range(1, 8) : $urandom_range(1, 32);
        // mostly keep the subnet aligned so that probes can hit it
        if (has_pfx && $urandom_range(0, 3) != 0)
            ip &= ~(32'hFFFF_FFFF >> pfx);
        for (int k = 0; k < n_oct; k++) begin
            if (k > 0)
                add_char(CH_DOT);
            if ($urandom_range(0, 15) == 0)
                add_char(CH_0);
            // occasionally spell the octet past 255 so it wraps back
            add_number(ip[8*(3-k) +: 8] +
                       256 * (($urandom_range(0, 11) == 0) ? $urandom_range(1, 3) : 0));
        end
        if (flt == FLT_JUNK) begin
            add_char(8'($urandom_range(1, 255)));
        end else if (flt == FLT_FIFTH) begin
            add_char(CH_DOT);
            add_number($urandom_range(0, 255));
        end
        if (flt == FLT_EMPTY_PFX) begin
            add_char(CH_SLASH);
        end else if (flt == FLT_PFX_RANGE) begin
            add_char(CH_SLASH);
            case ($urandom_range(0, 2))
                0:       add_number(0);
                1:       add_number($urandom_range(33, 255));
                default: add_number(256);
            endcase
        end else if (has_pfx) begin
            add_char(CH_SLASH);
            add_number(pfx + (($urandom_range(0, 15) == 0) ? 256 : 0));
        end
        if (flt == FLT_NONE) begin
            gen_subnets.push_back(ip);
            gen_prefixes.push_back(6'(has_pfx ? pfx : 32));
        end
    endtask

    // one list plus trailing probes; entries > 0 forces a long short-form list
    task automatic add_list(input int entries);
        int     kind, n, flt_at;
        bit     short_form;
        fault_t flt;
        gen_subnets.delete();
        gen_prefixes.delete();
        kind = (entries > 0) ? 20 : $urandom_range(0, 99);
        if (kind < 7) begin
            add_char(CH_NUL);
        end else if (kind < 14) begin
            add_char(CH_STAR);
            if ($urandom_range(0, 1) != 0)
                repeat ($urandom_range(1, 3)) add_char(8'($urandom_range(1, 255)));
            add_char(CH_NUL);
        end else begin
            short_form = kind < 22;
            if (entries > 0)
                n = entries;
            else if (short_form)
                n = ($urandom_range(0, 1) != 0) ? TBL_DEPTH : TBL_DEPTH + $urandom_range(1, 3);
            else
                n = $urandom_range(1, 5);
            flt_at = (!short_form && $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
            for (int j = 0; j < n; j++) begin
                if (j > 0)
                    add_char(CH_PLUS);
                if ($urandom_range(0, 5) == 0)
                    add_probe();
                flt = (j == flt_at) ? fault_t'($urandom_range(FLT_JUNK, FLT_SLASH_FIRST))
                                    : FLT_NONE;
                add_entry(flt, short_form);
            end
            // dangling separator leaves an empty address
            if ($urandom_range(0, 11) == 0)
                add_char(CH_PLUS);
            add_char(CH_NUL);
        end
        repeat ($urandom_range(1, 4)) add_probe();
    endtask

    //------------------------------------------------------------------
    // Input driver: bursts with random gaps
    //------------------------------------------------------------------
    always @(posedge aclk) begin : drive_p
        bit offer;
        offer = s_axis_tvalid;
        if (!aresetn) begin
            offer = 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_item(stim_q.pop_front());
                offer = 1'b0;
            end
            if (!offer && stim_q.size() != 0) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else begin
                    offer = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
            end
        end
        s_axis_tvalid <= offer;
        if (offer) begin
            s_axis_tdata <= {stim_q[0].peer, stim_q[0].ch};
            s_axis_tuser <= stim_q[0].action;
        end
    end

    //------------------------------------------------------------------
    // Result side: long hold-off once, otherwise a windowed stall pattern
    //------------------------------------------------------------------
    always @(posedge aclk) begin : hold_p
        if (!aresetn) begin
            hold_clock <= 0;
            hold_left  <= 0;
        end else begin
            hold_clock <= hold_clock + 1;
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (hold_clock == HOLD_START)
                hold_left <= HOLD_CYCLES;
        end
    end

    always @(posedge aclk) begin : rcv_p
        rcv_cyc <= rcv_cyc + 1'b1;
        if (!aresetn || hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            case (rcv_cyc[9:8])
                2'd0:    m_axis_tready <= 1'b1;
                2'd3:    m_axis_tready <= ($urandom_range(0, 5) == 0);
                default: m_axis_tready <= ($urandom_range(0, 2) != 0);
            endcase
        end
    end

    function automatic void report_field(input string what, input int unsigned want,
                                         input int unsigned got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    endfunction

    // compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : check_p
        verdict_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            n_results++;
            got.status  = status_t'(m_axis_tdata[2:0]);
            got.allowed = m_axis_tdata[3];
            got.count   = m_axis_tdata[9:4];
            if (verdict_q.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result, expected none, actual tdata 0x%h",
                         $time, m_axis_tdata);
            end else begin
                want = verdict_q.pop_front();
                if (got.status !== want.status)
                    report_field("status", want.status, got.status);
                if (got.allowed !== want.allowed)
                    report_field("allowed", want.allowed, got.allowed);
                if (got.count !== want.count)
                    report_field("entry_count", want.count, got.count);
            end
        end
    end

    always @(posedge aclk) begin : watchdog_p
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, verdict_q.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus, reset and end of run
    //------------------------------------------------------------------
    initial begin : stim_p
        int directed_items, n_lists;

        // empty table after reset permits everyone
        add_query(32'hFFFF_FFFF);
        // terminator alone: empty text
        add_char(CH_NUL);
        // lone star, then star followed by junk
        add_char(CH_STAR);
        add_char(CH_NUL);
        add_char(CH_STAR);
        add_char(CH_PLUS);
        add_char(CH_NUL);
        // one host entry, queried mid-list, then a bad character clears it
        add_char(CH_0 + 8'd9);
        add_char(CH_SLASH);
        add_number(32);
        add_char(CH_PLUS);
        add_query(32'h0900_0000);
        add_query(32'h0000_0000);
        add_char(8'hFF);
        add_char(CH_NUL);
        // empty prefix
        add_char(CH_0 + 8'd1);
        add_char(CH_SLASH);
        add_char(CH_NUL);
        add_query($urandom());

        directed_items = stim_q.size();
        n_lists = 0;
        while (stim_q.size() < directed_items + RANDOM_ITEMS) begin
            // make sure both a full table and an overflow come early
            if (n_lists == 1)
                add_list(TBL_DEPTH + 1);
            else if (n_lists == 4)
                add_list(TBL_DEPTH);
            else
                add_list(0);
            n_lists++;
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_axis_tvalid || verdict_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d list characters in %0d lists and %0d peer queries (%0d permitted).",
                 n_chars, n_terms, n_queries, n_permitted);
        $display("List outcomes: ok %0d, empty %0d, star %0d, bad address %0d, bad prefix %0d, %s",
                 status_hist[ST_OK], status_hist[ST_EMPTY], status_hist[ST_STAR],
                 status_hist[ST_BAD_ADDR], status_hist[ST_BAD_PREF],
                 $sformatf("too many %0d; peak table %0d, %0d results, %0d errors",
                           status_hist[ST_TOO_MANY], peak_count, n_results, n_errors));
        if (n_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
rtl/ipalm_pkg.sv
rtl/ipalm_parser.sv
rtl/ipalm_matcher.sv
rtl/ipv4_allow_list_parse_and_match_unit.sv
tb/sv/tb.sv
